### rtl/ps2_mouse_packet_to_hid_report_assert.svh
// Assertion macros for the mouse packet converter.
`ifndef PS2_MOUSE_PACKET_TO_HID_REPORT_ASSERT_SVH
`define PS2_MOUSE_PACKET_TO_HID_REPORT_ASSERT_SVH
`ifndef SYNTH
`define PS2HID_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ps2hid: same-cycle check failed");
`define PS2HID_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ps2hid: next-cycle check failed");
`else
`define PS2HID_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define PS2HID_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

### rtl/ps2hid_pkg.sv
package ps2hid_pkg;

   localparam int TIMER_BITS_DEF = 16;
   localparam int MAG_BITS       = 7;

   localparam logic [2:0]  SCROLL_BUTTONS_RST = 3'd4;
   localparam logic [6:0]  WHEEL_DIVISOR_RST  = 7'd2;
   localparam logic [6:0]  PAN_DIVISOR_RST    = 7'd2;
   localparam logic [15:0] TAP_WINDOW_RST     = 16'd0;

   localparam logic [7:0] SAT_POS  = 8'h7F;   // +127
   localparam logic [7:0] SAT_NEG  = 8'h81;   // -127
   localparam logic [7:0] GAP_BASE = 8'd100;

   typedef enum logic [1:0] {
      CSR_SCROLL_BUTTONS,
      CSR_WHEEL_DIVISOR,
      CSR_PAN_DIVISOR,
      CSR_TAP_WINDOW
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_HELD,
      MODE_SENT
   } scroll_mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_PLAN,
      ST_WHEEL_GO,
      ST_WHEEL_WAIT,
      ST_PAN_GO,
      ST_PAN_WAIT,
      ST_EMIT_TAP,
      ST_EMIT_MAIN
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic commit;
      logic div_start;
      logic div_sel_pan;
      logic store_wheel;
      logic store_pan;
      logic emit_tap;
      logic emit_main;
   } dp_cmd_type;

   typedef struct packed {
      logic need_wheel;
      logic need_pan;
      logic tap;
      logic send;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

### rtl/ps2hid_div.sv
module ps2hid_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [ps2hid_pkg::MAG_BITS-1:0]  dividend,
   input  logic [ps2hid_pkg::MAG_BITS-1:0]  divisor,
   output logic                             done,
   output logic [ps2hid_pkg::MAG_BITS-1:0]  quotient
);

   localparam int M        = ps2hid_pkg::MAG_BITS;
   localparam int CNT_BITS = $clog2(M);

   logic [M-1:0]        rem_ff, rem_in;
   logic [M-1:0]        quo_ff, quo_in;
   logic [M-1:0]        div_ff, div_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [M:0] shifted;
   logic [M:0] trial;
   logic       fits;

   // One quotient bit per cycle, restoring form.
   assign shifted = {rem_ff, quo_ff[M-1]};
   assign trial   = shifted - {1'b0, div_ff};
   assign fits    = !trial[M];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = (divisor == '0) ? M'(1) : divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial[M-1:0] : shifted[M-1:0];
         quo_in = {quo_ff[M-2:0], fits};
         cnt_in = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(M - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/ps2hid_ctrl.sv
module ps2hid_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  ps2hid_pkg::dp_status_type status,
   output ps2hid_pkg::dp_cmd_type    cmd
);

   ps2hid_pkg::ctrl_state_type state_ff, state_in;

   // Picks the first remaining step once a packet has been evaluated.
   function automatic ps2hid_pkg::ctrl_state_type pick_next(
      input logic want_pan,
      input logic want_tap,
      input logic want_send
   );
      ps2hid_pkg::ctrl_state_type nxt;
      begin
         if (want_pan)
            nxt = ps2hid_pkg::ST_PAN_GO;
         else if (want_tap)
            nxt = ps2hid_pkg::ST_EMIT_TAP;
         else if (want_send)
            nxt = ps2hid_pkg::ST_EMIT_MAIN;
         else
            nxt = ps2hid_pkg::ST_IDLE;
         return nxt;
      end
   endfunction

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ps2hid_pkg::ST_IDLE: begin
            if (req_valid)
               state_in = ps2hid_pkg::ST_EVAL;
         end
         ps2hid_pkg::ST_EVAL: begin
            state_in = ps2hid_pkg::ST_PLAN;
         end
         ps2hid_pkg::ST_PLAN: begin
            if (status.need_wheel)
               state_in = ps2hid_pkg::ST_WHEEL_GO;
            else
               state_in = pick_next(status.need_pan, status.tap, status.send);
         end
         ps2hid_pkg::ST_WHEEL_GO: begin
            state_in = ps2hid_pkg::ST_WHEEL_WAIT;
         end
         ps2hid_pkg::ST_WHEEL_WAIT: begin
            if (status.div_done)
               state_in = pick_next(status.need_pan, status.tap, status.send);
         end
         ps2hid_pkg::ST_PAN_GO: begin
            state_in = ps2hid_pkg::ST_PAN_WAIT;
         end
         ps2hid_pkg::ST_PAN_WAIT: begin
            if (status.div_done)
               state_in = pick_next(1'b0, status.tap, status.send);
         end
         ps2hid_pkg::ST_EMIT_TAP: begin
            if (status.out_free)
               state_in = pick_next(1'b0, 1'b0, status.send);
         end
         ps2hid_pkg::ST_EMIT_MAIN: begin
            if (status.out_free)
               state_in = ps2hid_pkg::ST_IDLE;
         end
         default: begin
            state_in = ps2hid_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready       = (state_ff == ps2hid_pkg::ST_IDLE);
      cmd             = '0;
      cmd.load        = req_valid && (state_ff == ps2hid_pkg::ST_IDLE);
      cmd.commit      = (state_ff == ps2hid_pkg::ST_EVAL);
      cmd.div_start   = (state_ff == ps2hid_pkg::ST_WHEEL_GO) ||
                        (state_ff == ps2hid_pkg::ST_PAN_GO);
      cmd.div_sel_pan = (state_ff == ps2hid_pkg::ST_PAN_GO);
      cmd.store_wheel = (state_ff == ps2hid_pkg::ST_WHEEL_WAIT) && status.div_done;
      cmd.store_pan   = (state_ff == ps2hid_pkg::ST_PAN_WAIT) && status.div_done;
      cmd.emit_tap    = (state_ff == ps2hid_pkg::ST_EMIT_TAP) && status.out_free;
      cmd.emit_main   = (state_ff == ps2hid_pkg::ST_EMIT_MAIN) && status.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ps2hid_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/ps2hid_dp.sv
module ps2hid_dp #(
   parameter int TIMER_BITS = ps2hid_pkg::TIMER_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [1:0]                csr_index,
   input  logic [15:0]               csr_wdata,
   input  logic                      req_packet_ok,
   input  logic [7:0]                req_status_byte,
   input  logic [7:0]                req_x_low,
   input  logic [7:0]                req_y_low,
   input  logic [15:0]               req_now_ms,
   input  ps2hid_pkg::dp_cmd_type    cmd,
   output ps2hid_pkg::dp_status_type status,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [2:0]                rsp_buttons,
   output logic signed [7:0]         rsp_move_x,
   output logic signed [7:0]         rsp_move_y,
   output logic signed [7:0]         rsp_wheel,
   output logic signed [7:0]         rsp_pan,
   output logic                      rsp_last
);

   localparam int M        = ps2hid_pkg::MAG_BITS;
   localparam int CMP_BITS = (TIMER_BITS > 16) ? TIMER_BITS : 16;

   function automatic logic [7:0] sat9(
      input logic [7:0] low,
      input logic       neg,
      input logic       ovf
   );
      logic fits;
      begin
         fits = neg ? (!ovf && low[7] && (low != 8'h80)) : (!ovf && !low[7]);
         if (fits)
            return low;
         return neg ? ps2hid_pkg::SAT_NEG : ps2hid_pkg::SAT_POS;
      end
   endfunction

   function automatic logic [M-1:0] mag(input logic [7:0] v);
      logic [7:0] a;
      begin
         a = v[7] ? (~v + 8'd1) : v;
         return a[M-1:0];
      end
   endfunction

   // Configuration
   logic [2:0]  scroll_buttons_ff, scroll_buttons_in;
   logic [6:0]  wheel_div_ff, wheel_div_in;
   logic [6:0]  pan_div_ff, pan_div_in;
   logic [15:0] tap_window_ff, tap_window_in;

   // Captured packet
   logic                  ok_ff, ok_in;
   logic [7:0]            status_ff, status_in;
   logic [7:0]            xl_ff, xl_in;
   logic [7:0]            yl_ff, yl_in;
   logic [TIMER_BITS-1:0] now_ff, now_in;

   // Converter state
   ps2hid_pkg::scroll_mode_type mode_ff, mode_in;
   logic [2:0]            prev_btn_ff, prev_btn_in;
   logic [TIMER_BITS-1:0] press_time_ff, press_time_in;
   logic [TIMER_BITS-1:0] last_send_ff, last_send_in;
   logic [M-1:0]          gap_ff, gap_in;
   logic [M-1:0]          abs_x_ff, abs_x_in;
   logic [M-1:0]          abs_y_ff, abs_y_in;

   // Plan for the packet being worked on
   logic       need_wheel_ff, need_wheel_in;
   logic       need_pan_ff, need_pan_in;
   logic       tap_ff, tap_in;
   logic       send_ff, send_in;
   logic [2:0] rep_btn_ff, rep_btn_in;
   logic [7:0] rep_x_ff, rep_x_in;
   logic [7:0] rep_y_ff, rep_y_in;
   logic       wheel_neg_ff, wheel_neg_in;
   logic       pan_neg_ff, pan_neg_in;
   logic [7:0] wheel_ff, wheel_in;
   logic [7:0] pan_ff, pan_in;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_buttons_ff, rsp_buttons_in;
   logic [7:0] rsp_x_ff, rsp_x_in;
   logic [7:0] rsp_y_ff, rsp_y_in;
   logic [7:0] rsp_wheel_ff, rsp_wheel_in;
   logic [7:0] rsp_pan_ff, rsp_pan_in;
   logic       rsp_last_ff, rsp_last_in;

   // Evaluation
   logic [2:0]            btn;
   logic [7:0]            x_val, y_sat, y_val;
   logic                  drop, scroll_on, full, released, moving, scroll_move;
   logic [M-1:0]          new_abs_x, new_abs_y, new_gap, gap_eff;
   logic [7:0]            abs_sum;
   logic [TIMER_BITS-1:0] press_diff, send_diff;
   logic                  tap_hit, late;
   ps2hid_pkg::scroll_mode_type mode_nx;

   // Divider
   logic [M-1:0] div_dividend, div_divisor, div_quot, q_adj;
   logic         div_done;
   logic [7:0]   q_mag, q_pos, q_neg;
   logic         out_free;

   assign btn         = status_ff[2:0];
   assign x_val       = sat9(xl_ff, status_ff[4], status_ff[6]);
   assign y_sat       = sat9(yl_ff, status_ff[5], status_ff[7]);
   assign y_val       = ~y_sat + 8'd1;
   assign drop        = !ok_ff || ((xl_ff == 8'd0) && (yl_ff == 8'd0) && (btn == prev_btn_ff));
   assign scroll_on   = (scroll_buttons_ff != 3'd0);
   assign full        = ((btn & scroll_buttons_ff) == scroll_buttons_ff);
   assign released    = ((btn & scroll_buttons_ff) == 3'd0);
   assign moving      = (x_val != 8'd0) || (y_val != 8'd0);
   assign scroll_move = scroll_on && full && moving;

   assign new_abs_x = (scroll_move && (x_val != 8'd0)) ? mag(x_val) : abs_x_ff;
   assign new_abs_y = (scroll_move && (y_val != 8'd0)) ? mag(y_val) : abs_y_ff;
   assign abs_sum   = {1'b0, new_abs_x} + {1'b0, new_abs_y};
   assign new_gap   = (abs_sum >= ps2hid_pkg::GAP_BASE) ? '0
                      : M'(ps2hid_pkg::GAP_BASE - abs_sum);
   assign gap_eff   = scroll_move ? new_gap : gap_ff;

   assign press_diff = now_ff - press_time_ff;
   assign send_diff  = now_ff - last_send_ff;
   assign tap_hit    = scroll_on && released && (mode_ff != ps2hid_pkg::MODE_NONE) &&
                       (CMP_BITS'(press_diff) < CMP_BITS'(tap_window_ff));
   assign late       = (send_diff > TIMER_BITS'(gap_eff));

   always_comb begin
      mode_nx = mode_ff;
      if (scroll_on) begin
         if (full) begin
            if (mode_ff == ps2hid_pkg::MODE_NONE)
               mode_nx = ps2hid_pkg::MODE_HELD;
            if (moving)
               mode_nx = ps2hid_pkg::MODE_SENT;
         end else if (released) begin
            mode_nx = ps2hid_pkg::MODE_NONE;
         end
      end
   end

   // Configuration writes
   always_comb begin
      scroll_buttons_in = scroll_buttons_ff;
      wheel_div_in      = wheel_div_ff;
      pan_div_in        = pan_div_ff;
      tap_window_in     = tap_window_ff;
      if (csr_we) begin
         case (csr_index)
            ps2hid_pkg::CSR_SCROLL_BUTTONS: scroll_buttons_in = csr_wdata[2:0];
            ps2hid_pkg::CSR_WHEEL_DIVISOR:  wheel_div_in      = csr_wdata[6:0];
            ps2hid_pkg::CSR_PAN_DIVISOR:    pan_div_in        = csr_wdata[6:0];
            ps2hid_pkg::CSR_TAP_WINDOW:     tap_window_in     = csr_wdata;
            default: ;
         endcase
      end
   end

   // Packet capture
   always_comb begin
      ok_in     = ok_ff;
      status_in = status_ff;
      xl_in     = xl_ff;
      yl_in     = yl_ff;
      now_in    = now_ff;
      if (cmd.load) begin
         ok_in     = req_packet_ok;
         status_in = req_status_byte;
         xl_in     = req_x_low;
         yl_in     = req_y_low;
         now_in    = TIMER_BITS'(req_now_ms);
      end
   end

   // State update and plan at evaluation; quotients stored on done.
   always_comb begin
      mode_in       = mode_ff;
      prev_btn_in   = prev_btn_ff;
      press_time_in = press_time_ff;
      last_send_in  = last_send_ff;
      gap_in        = gap_ff;
      abs_x_in      = abs_x_ff;
      abs_y_in      = abs_y_ff;
      need_wheel_in = need_wheel_ff;
      need_pan_in   = need_pan_ff;
      tap_in        = tap_ff;
      send_in       = send_ff;
      rep_btn_in    = rep_btn_ff;
      rep_x_in      = rep_x_ff;
      rep_y_in      = rep_y_ff;
      wheel_neg_in  = wheel_neg_ff;
      pan_neg_in    = pan_neg_ff;
      wheel_in      = wheel_ff;
      pan_in        = pan_ff;
      if (cmd.commit) begin
         need_wheel_in = !drop && scroll_move && (y_val != 8'd0);
         need_pan_in   = !drop && scroll_move && (x_val != 8'd0);
         tap_in        = !drop && tap_hit;
         send_in       = !drop && (!scroll_on || (mode_nx != ps2hid_pkg::MODE_SENT) || late);
         rep_btn_in    = btn;
         rep_x_in      = scroll_move ? 8'd0 : x_val;
         rep_y_in      = scroll_move ? 8'd0 : y_val;
         // Wheel follows inverted Y, so a positive Y scrolls negative.
         wheel_neg_in  = !y_val[7];
         pan_neg_in    = x_val[7];
         wheel_in      = 8'd0;
         pan_in        = 8'd0;
         if (!drop) begin
            prev_btn_in = btn;
            if (scroll_on) begin
               mode_in  = mode_nx;
               abs_x_in = new_abs_x;
               abs_y_in = new_abs_y;
               gap_in   = gap_eff;
               if (full && (mode_ff == ps2hid_pkg::MODE_NONE))
                  press_time_in = now_ff;
               if ((mode_nx != ps2hid_pkg::MODE_SENT) || late)
                  last_send_in = now_ff;
            end
         end
      end
      if (cmd.store_wheel)
         wheel_in = wheel_neg_ff ? q_neg : q_pos;
      if (cmd.store_pan)
         pan_in = pan_neg_ff ? q_neg : q_pos;
   end

   assign div_dividend = cmd.div_sel_pan ? abs_x_ff : abs_y_ff;
   assign div_divisor  = cmd.div_sel_pan ? pan_div_ff : wheel_div_ff;

   ps2hid_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   // A step that rounds to zero still moves by one.
   assign q_adj = (div_quot == '0) ? M'(1) : div_quot;
   assign q_mag = 8'(q_adj);
   assign q_pos = q_mag;
   assign q_neg = ~q_mag + 8'd1;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_buttons_in = rsp_buttons_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_wheel_in   = rsp_wheel_ff;
      rsp_pan_in     = rsp_pan_ff;
      rsp_last_in    = rsp_last_ff;
      if (cmd.emit_tap) begin
         rsp_valid_in   = 1'b1;
         rsp_buttons_in = rep_btn_ff | scroll_buttons_ff;
         rsp_x_in       = rep_x_ff;
         rsp_y_in       = rep_y_ff;
         rsp_wheel_in   = 8'd0;
         rsp_pan_in     = 8'd0;
         rsp_last_in    = 1'b0;
      end else if (cmd.emit_main) begin
         rsp_valid_in   = 1'b1;
         rsp_buttons_in = rep_btn_ff & ~scroll_buttons_ff;
         rsp_x_in       = rep_x_ff;
         rsp_y_in       = rep_y_ff;
         rsp_wheel_in   = wheel_ff;
         rsp_pan_in     = pan_ff;
         rsp_last_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      ok_in_reg: begin
         ok_ff     <= ok_in;
         status_ff <= status_in;
         xl_ff     <= xl_in;
         yl_ff     <= yl_in;
         now_ff    <= now_in;
      end
      need_wheel_ff  <= need_wheel_in;
      need_pan_ff    <= need_pan_in;
      tap_ff         <= tap_in;
      send_ff        <= send_in;
      rep_btn_ff     <= rep_btn_in;
      rep_x_ff       <= rep_x_in;
      rep_y_ff       <= rep_y_in;
      wheel_neg_ff   <= wheel_neg_in;
      pan_neg_ff     <= pan_neg_in;
      wheel_ff       <= wheel_in;
      pan_ff         <= pan_in;
      rsp_buttons_ff <= rsp_buttons_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_wheel_ff   <= rsp_wheel_in;
      rsp_pan_ff     <= rsp_pan_in;
      rsp_last_ff    <= rsp_last_in;
      if (reset) begin
         scroll_buttons_ff <= ps2hid_pkg::SCROLL_BUTTONS_RST;
         wheel_div_ff      <= ps2hid_pkg::WHEEL_DIVISOR_RST;
         pan_div_ff        <= ps2hid_pkg::PAN_DIVISOR_RST;
         tap_window_ff     <= ps2hid_pkg::TAP_WINDOW_RST;
         mode_ff           <= ps2hid_pkg::MODE_NONE;
         prev_btn_ff       <= '0;
         press_time_ff     <= '0;
         last_send_ff      <= '0;
         gap_ff            <= M'(ps2hid_pkg::GAP_BASE);
         abs_x_ff          <= '0;
         abs_y_ff          <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         scroll_buttons_ff <= scroll_buttons_in;
         wheel_div_ff      <= wheel_div_in;
         pan_div_ff        <= pan_div_in;
         tap_window_ff     <= tap_window_in;
         mode_ff           <= mode_in;
         prev_btn_ff       <= prev_btn_in;
         press_time_ff     <= press_time_in;
         last_send_ff      <= last_send_in;
         gap_ff            <= gap_in;
         abs_x_ff          <= abs_x_in;
         abs_y_ff          <= abs_y_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_comb begin
      status            = '0;
      status.need_wheel = need_wheel_ff;
      status.need_pan   = need_pan_ff;
      status.tap        = tap_ff;
      status.send       = send_ff;
      status.div_done   = div_done;
      status.out_free   = out_free;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_buttons = rsp_buttons_ff;
   assign rsp_move_x  = rsp_x_ff;
   assign rsp_move_y  = rsp_y_ff;
   assign rsp_wheel   = rsp_wheel_ff;
   assign rsp_pan     = rsp_pan_ff;
   assign rsp_last    = rsp_last_ff;

endmodule

### rtl/ps2_mouse_packet_to_hid_report.sv
// A packet is accepted in the idle state, evaluated, planned and then emitted as a
// registered report; each wheel or pan step runs through a 7-step serial divider,
// and a tap report goes out ahead of any main one (a tap never comes with a
// division). One packet is worked on at a time, and the next is taken while a
// report waits.
// Reset is synchronous: configuration returns to its defaults, scroll state clears.
// There is no clearing pass; the block is ready in the cycle after reset.
`include "ps2_mouse_packet_to_hid_report_assert.svh"

module ps2_mouse_packet_to_hid_report #(
   parameter int TIMER_BITS = ps2hid_pkg::TIMER_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_packet_ok,
   input  logic [7:0]         req_status_byte,
   input  logic [7:0]         req_x_low,
   input  logic [7:0]         req_y_low,
   input  logic [15:0]        req_now_ms,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_buttons,
   output logic signed [7:0]  rsp_move_x,
   output logic signed [7:0]  rsp_move_y,
   output logic signed [7:0]  rsp_wheel,
   output logic signed [7:0]  rsp_pan,
   output logic               rsp_last
);

   ps2hid_pkg::dp_cmd_type    dp_cmd;
   ps2hid_pkg::dp_status_type dp_status;

   ps2hid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   ps2hid_dp #(
      .TIMER_BITS (TIMER_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_packet_ok   (req_packet_ok),
      .req_status_byte (req_status_byte),
      .req_x_low       (req_x_low),
      .req_y_low       (req_y_low),
      .req_now_ms      (req_now_ms),
      .cmd             (dp_cmd),
      .status          (dp_status),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_buttons     (rsp_buttons),
      .rsp_move_x      (rsp_move_x),
      .rsp_move_y      (rsp_move_y),
      .rsp_wheel       (rsp_wheel),
      .rsp_pan         (rsp_pan),
      .rsp_last        (rsp_last)
   );

   // An accepted item is always evaluated in the following cycle.
   `PS2HID_ASSERT_NXT(a_accept_eval, clock, reset, req_valid && req_ready, dp_cmd.commit)
   // A tap report is never the final one of its packet.
   `PS2HID_ASSERT_NXT(a_tap_not_last, clock, reset, dp_cmd.emit_tap, rsp_valid && !rsp_last)
   `PS2HID_ASSERT_NXT(a_main_last, clock, reset, dp_cmd.emit_main, rsp_valid && rsp_last)
   // The result register is only loaded when it is free.
   `PS2HID_ASSERT_IMP(a_emit_free, clock, reset, dp_cmd.emit_tap || dp_cmd.emit_main,
                      !rsp_valid || rsp_ready)

endmodule

### bench/ps2_mouse_packet_to_hid_report_tb.sv
`timescale 1ns / 100ps

module ps2_mouse_packet_to_hid_report_tb;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int ITEMS_PER_PHASE = 128;
   localparam int PRINT_LIMIT     = 50;

   typedef struct packed {
      logic [2:0] buttons;
      logic [7:0] move_x;
      logic [7:0] move_y;
      logic [7:0] wheel;
      logic [7:0] pan;
      logic       last;
   } hid_report_type;

   typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_wdata = 16'd0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_packet_ok = 1'b0;
   logic [7:0]  req_status_byte = 8'd0;
   logic [7:0]  req_x_low = 8'd0;
   logic [7:0]  req_y_low = 8'd0;
   logic [15:0] req_now_ms = 16'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_buttons;
   logic signed [7:0] rsp_move_x;
   logic signed [7:0] rsp_move_y;
   logic signed [7:0] rsp_wheel;
   logic signed [7:0] rsp_pan;
   logic        rsp_last;

   // Configuration and scroll state as the block should hold them.
   bit [2:0]        cfg_scroll_buttons = 3'd4;
   bit [6:0]        cfg_wheel_divisor  = 7'd2;
   bit [6:0]        cfg_pan_divisor    = 7'd2;
   bit [15:0]       cfg_tap_window     = 16'd0;
   ps2hid_pkg::scroll_mode_type emu_mode = ps2hid_pkg::MODE_NONE;
   bit [2:0]        prev_buttons       = 3'd0;
   bit [15:0]       press_ms           = 16'd0;
   bit [15:0]       last_send_ms       = 16'd0;
   int              scroll_gap         = 100;
   int              abs_x_seen         = 0;
   int              abs_y_seen         = 0;

   hid_report_type pending_reports[$];
   hid_report_type head_report;
   int             mismatch_count = 0;
   int             report_count   = 0;
   int             cycle_count    = 0;
   int             burst_left     = 0;
   bit [15:0]      clock_ms       = 16'd10000;
   rx_pattern_type rx_pattern     = RX_ALWAYS;
   int             rx_pattern_left = 0;

   ps2_mouse_packet_to_hid_report uut (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_packet_ok   (req_packet_ok),
      .req_status_byte (req_status_byte),
      .req_x_low       (req_x_low),
      .req_y_low       (req_y_low),
      .req_now_ms      (req_now_ms),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_buttons     (rsp_buttons),
      .rsp_move_x      (rsp_move_x),
      .rsp_move_y      (rsp_move_y),
      .rsp_wheel       (rsp_wheel),
      .rsp_pan         (rsp_pan),
      .rsp_last        (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_LIMIT) $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // A sign bit that disagrees with the value, or an overflow, pins the result to
   // the extreme in the direction of the sign.
   function automatic int saturate_delta(input bit [7:0] low, input bit neg, input bit ovf);
      int v;
      v = low[7] ? int'(low) - 256 : int'(low);
      if (neg) return (!ovf && v >= -127 && v <= -1) ? v : -127;
      return (!ovf && v >= 0 && v <= 127) ? v : 127;
   endfunction

   function automatic int scroll_steps(input int movement, input bit [6:0] divisor);
      int q;
      q = movement / ((divisor == 0) ? 1 : int'(divisor));
      if (q == 0) q = (movement < 0) ? -1 : 1;
      return q;
   endfunction

   function automatic void push_report(input bit [2:0] b, input int mx, input int my,
                                       input int whl, input int pn, input bit last);
      hid_report_type r;
      r.buttons = b;
      r.move_x  = mx[7:0];
      r.move_y  = my[7:0];
      r.wheel   = whl[7:0];
      r.pan     = pn[7:0];
      r.last    = last;
      pending_reports.push_back(r);
   endfunction

   function automatic void predict_reports(input bit ok, input bit [7:0] status,
                                           input bit [7:0] xl, input bit [7:0] yl,
                                           input bit [15:0] t);
      bit [2:0]  btn;
      bit [2:0]  mask;
      bit [15:0] elapsed;
      int        mx, my, whl, pn, sum;
      whl = 0;
      pn = 0;
      btn = status[2:0];
      if (!ok || (xl == 8'd0 && yl == 8'd0 && btn == prev_buttons)) return;
      prev_buttons = btn;
      mx = saturate_delta(xl, status[4], status[6]);
      my = -saturate_delta(yl, status[5], status[7]);
      mask = cfg_scroll_buttons;
      if (mask == 3'd0) begin
         push_report(btn, mx, my, 0, 0, 1'b1);
         return;
      end
      if ((btn & mask) == mask) begin
         if (emu_mode == ps2hid_pkg::MODE_NONE) begin
            press_ms = t;
            emu_mode = ps2hid_pkg::MODE_HELD;
         end
         if (mx != 0 || my != 0) begin
            emu_mode = ps2hid_pkg::MODE_SENT;
            if (my != 0) begin
               abs_y_seen = (my < 0) ? -my : my;
               whl = scroll_steps(-my, cfg_wheel_divisor);
            end
            if (mx != 0) begin
               abs_x_seen = (mx < 0) ? -mx : mx;
               pn = scroll_steps(mx, cfg_pan_divisor);
            end
            sum = abs_x_seen + abs_y_seen;
            scroll_gap = (sum >= 100) ? 0 : 100 - sum;
            mx = 0;
            my = 0;
         end
      end else if ((btn & mask) == 3'd0) begin
         elapsed = t - press_ms;
         if (emu_mode != ps2hid_pkg::MODE_NONE && elapsed < cfg_tap_window)
            push_report(btn | mask, mx, my, 0, 0, 1'b0);
         emu_mode = ps2hid_pkg::MODE_NONE;
      end
      btn = btn & ~mask;
      if (emu_mode == ps2hid_pkg::MODE_SENT) begin
         elapsed = t - last_send_ms;
         if (int'(elapsed) > scroll_gap) begin
            push_report(btn, mx, my, whl, pn, 1'b1);
            last_send_ms = t;
         end
      end else begin
         last_send_ms = t;
         push_report(btn, mx, my, whl, pn, 1'b1);
      end
   endfunction

   // Valid stays high between items of a burst; this task only drops it for a gap.
   task automatic send_packet(input bit ok, input bit [7:0] status, input bit [7:0] xl,
                              input bit [7:0] yl, input bit [15:0] t);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_packet_ok   <= ok;
      req_status_byte <= status;
      req_x_low       <= xl;
      req_y_low       <= yl;
      req_now_ms      <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_reports(ok, status, xl, yl, t);
   endtask

   task automatic wait_drained;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write_one(input ps2hid_pkg::csr_index_type idx, input bit [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         ps2hid_pkg::CSR_SCROLL_BUTTONS: cfg_scroll_buttons = data[2:0];
         ps2hid_pkg::CSR_WHEEL_DIVISOR:  cfg_wheel_divisor  = data[6:0];
         ps2hid_pkg::CSR_PAN_DIVISOR:    cfg_pan_divisor    = data[6:0];
         ps2hid_pkg::CSR_TAP_WINDOW:     cfg_tap_window     = data;
         default: ;
      endcase
   endtask

   task automatic write_config(input bit [2:0] buttons, input bit [6:0] wheel_div,
                               input bit [6:0] pan_div, input bit [15:0] tap_window);
      csr_write_one(ps2hid_pkg::CSR_SCROLL_BUTTONS, {13'd0, buttons});
      csr_write_one(ps2hid_pkg::CSR_WHEEL_DIVISOR, {9'd0, wheel_div});
      csr_write_one(ps2hid_pkg::CSR_PAN_DIVISOR, {9'd0, pan_div});
      csr_write_one(ps2hid_pkg::CSR_TAP_WINDOW, tap_window);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly small movements, with extremes, full nine-bit values and overflows mixed in.
   task automatic send_motion(input bit [2:0] btn, input int dt);
      bit [8:0] d9 [2];
      bit [1:0] ovf;
      int       v;
      for (int i = 0; i < 2; i++) begin
         case ($urandom_range(0, 7))
            0:       v = 0;
            1, 2, 3: v = $urandom_range(0, 20) - 10;
            4, 5:    v = $urandom_range(0, 254) - 127;
            6:       v = $urandom_range(0, 511) - 256;
            default: v = ($urandom_range(0, 1) == 0) ? 127 : -127;
         endcase
         d9[i] = v[8:0];
         ovf[i] = ($urandom_range(0, 15) == 0);
      end
      clock_ms = clock_ms + dt[15:0];
      send_packet(1'b1, {ovf[1], ovf[0], d9[1][8], d9[0][8], 1'b1, btn},
                  d9[0][7:0], d9[1][7:0], clock_ms);
   endtask

   task automatic test_pointer_basics;
      write_config(3'd4, 7'd2, 7'd2, 16'd0);
      send_packet(1'b0, 8'h0F, 8'h10, 8'h10, 16'd10);
      send_packet(1'b1, 8'h08, 8'h00, 8'h00, 16'd20);
      send_packet(1'b1, 8'h09, 8'h00, 8'h00, 16'd30);
      send_packet(1'b1, 8'h08, 8'h7F, 8'h7F, 16'd40);
      send_packet(1'b1, 8'h38, 8'h81, 8'h80, 16'd50);
      send_packet(1'b1, 8'hC8, 8'h01, 8'h01, 16'd60);
      send_packet(1'b1, 8'hF8, 8'hFF, 8'hFF, 16'd70);
      // A sign bit set over a positive low byte, and the reverse.
      send_packet(1'b1, 8'h18, 8'h05, 8'h80, 16'd80);
      send_packet(1'b1, 8'h3B, 8'hFF, 8'hFF, 16'd90);
      send_packet(1'b1, 8'h0A, 8'h03, 8'h00, 16'd100);
   endtask

   task automatic test_scroll_gestures;
      wait_drained();
      write_config(3'd4, 7'd3, 7'd0, 16'd300);
      send_packet(1'b1, 8'h0C, 8'h00, 8'h00, 16'd1000);
      send_packet(1'b1, 8'h0C, 8'h14, 8'h0A, 16'd1100);
      // Too soon after the last scroll report, so nothing goes out.
      send_packet(1'b1, 8'h0C, 8'h01, 8'h00, 16'd1120);
      send_packet(1'b1, 8'h08, 8'h00, 8'h00, 16'd1200);
      send_packet(1'b1, 8'h0C, 8'h00, 8'h00, 16'd2000);
      send_packet(1'b1, 8'h08, 8'h00, 8'h00, 16'd2050);
      // Large movement drives the rate limit gap down to zero.
      send_packet(1'b1, 8'h0C, 8'h00, 8'h00, 16'd3000);
      send_packet(1'b1, 8'h2C, 8'h7F, 8'h81, 16'd3001);
      send_packet(1'b1, 8'h08, 8'h00, 8'h00, 16'd9000);
      // The tap window is measured across a timer wrap.
      send_packet(1'b1, 8'h0C, 8'h00, 8'h00, 16'd65500);
      send_packet(1'b1, 8'h08, 8'h00, 8'h00, 16'd20);
   endtask

   task automatic test_partial_and_disabled;
      wait_drained();
      write_config(3'd6, 7'd1, 7'd127, 16'd65535);
      send_packet(1'b1, 8'h0A, 8'h02, 8'h00, 16'd200);
      send_packet(1'b1, 8'h0E, 8'h03, 8'h00, 16'd400);
      send_packet(1'b1, 8'h08, 8'h00, 8'h00, 16'd450);
      wait_drained();
      write_config(3'd0, 7'd2, 7'd2, 16'd100);
      send_packet(1'b1, 8'h0F, 8'h20, 8'hE0, 16'd500);
      send_packet(1'b1, 8'h08, 8'h00, 8'h00, 16'd510);
   endtask

   task automatic test_random_traffic;
      int       items;
      int       moves;
      bit [2:0] btn;
      for (int phase = 0; phase < 9; phase++) begin
         wait_drained();
         case (phase)
            0: write_config(3'd7, 7'd127, 7'd1, 16'd65535);
            1: write_config(3'd0, 7'd1, 7'd127, 16'd0);
            2: write_config(3'd1, 7'd0, 7'd3, 16'd250);
            3: write_config(3'd6, 7'd5, 7'd0, 16'd100);
            4: write_config(3'd4, 7'd2, 7'd2, 16'd1);
            5: write_config(3'd2, 7'd9, 7'd17, 16'd600);
            6: write_config(3'd5, 7'd64, 7'd4, 16'd40);
            7: write_config(3'd3, 7'd3, 7'd90, 16'd2000);
            default: write_config(3'($urandom_range(1, 7)), 7'($urandom_range(0, 127)),
                                  7'($urandom_range(0, 127)), 16'($urandom_range(0, 65535)));
         endcase
         items = 0;
         while (items < ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 99) == 0) wait_drained();
            if ($urandom_range(0, 9) < 7) begin
               // Press the scroll buttons, move a while, then let go.
               send_motion(cfg_scroll_buttons | 3'($urandom_range(0, 7)), $urandom_range(0, 60));
               moves = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               repeat (moves) begin
                  btn = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                        : cfg_scroll_buttons | 3'($urandom_range(0, 7));
                  send_motion(btn, $urandom_range(0, 150));
               end
               send_motion(3'($urandom_range(0, 7)) & ~cfg_scroll_buttons,
                           $urandom_range(0, 400));
               items += moves + 2;
            end else begin
               clock_ms = clock_ms + 16'(($urandom_range(0, 7) == 0) ?
                          $urandom_range(0, 65535) : $urandom_range(0, 300));
               btn = 3'($urandom_range(0, 7));
               if ($urandom_range(0, 7) == 0) begin
                  send_packet(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), clock_ms);
               end else begin
                  send_packet(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)), clock_ms);
                  items++;
               end
            end
         end
      end
   endtask

   // The receiver switches between stall patterns, picked at random.
   always @(posedge clock) begin
      if (rx_pattern_left == 0) begin
         rx_pattern = rx_pattern_type'($urandom_range(0, 3));
         rx_pattern_left = $urandom_range(20, 300);
      end else begin
         rx_pattern_left--;
      end
      case (rx_pattern)
         RX_ALWAYS: rsp_ready <= 1'b1;
         RX_COIN:   rsp_ready <= ($urandom_range(0, 1) == 1);
         RX_SPARSE: rsp_ready <= ($urandom_range(0, 5) == 0);
         default:   rsp_ready <= ((cycle_count % 7) > 2);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         report_count++;
         if (pending_reports.size() == 0) begin
            report_mismatch($sformatf("report %0d arrived with none expected", report_count));
         end else begin
            head_report = pending_reports.pop_front();
            if ({rsp_buttons, rsp_move_x, rsp_move_y, rsp_wheel, rsp_pan, rsp_last}
                !== head_report)
               report_mismatch($sformatf(
                  "report %0d got btn %h x %h y %h whl %h pan %h last %b, want %h %h %h %h %h %b",
                  report_count, rsp_buttons, rsp_move_x, rsp_move_y, rsp_wheel, rsp_pan,
                  rsp_last, head_report.buttons, head_report.move_x, head_report.move_y,
                  head_report.wheel, head_report.pan, head_report.last));
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_pointer_basics();
      test_scroll_gestures();
      test_partial_and_disabled();
      test_random_traffic();
      req_valid <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && pending_reports.size() != 0; n++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_reports.size() != 0)
         report_mismatch($sformatf("%0d expected reports never arrived",
                                   pending_reports.size()));
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
